>>> rtl/core/scs_pkg.sv
// ---------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the source comment stripper.
// ---------------------------------------------------------------------------
package scs_pkg;

	localparam int HOLD_DEPTH_DEF = 32;

	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_SL = 8'd47;
	localparam logic [7:0] CH_ST = 8'd42;
	localparam logic [7:0] CH_DQ = 8'd34;
	localparam logic [7:0] CH_SQ = 8'd39;

	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
	localparam logic [1:0] QUOTE_SINGLE = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_LINE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_DOC   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_BLOCK = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_BLANK  = 2'd3;

	typedef struct packed {
		logic [7:0] src_byte;
		logic [7:0] ahead_one;
		logic [7:0] ahead_two;
	} src_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       truncated;
	} res_item_t;

	typedef struct packed {
		logic load;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic has_results;
		logic last;
		logic out_free;
	} ctl_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} ctl_state_t;

endpackage

>>> rtl/core/scs_ctrl.sv
// ---------------------------------------------------------------------------
// scs_ctrl
// Sequencer: takes a request, then steps the datapath through its results.
// ---------------------------------------------------------------------------
module scs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  scs_pkg::ctl_sts_t sts,
	output scs_pkg::ctl_cmd_t cmd
);
	import scs_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		src_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				src_stall = 1'b0;
				if (src_valid) begin
					cmd.load = 1'b1;
					if (sts.has_results) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/scs_datapath.sv
// ---------------------------------------------------------------------------
// scs_datapath
// Line/comment state, hold store for the blank prefix, result register.
// ---------------------------------------------------------------------------
module scs_datapath #(
	parameter int HOLD_DEPTH = scs_pkg::HOLD_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  scs_pkg::src_item_t                   src_item,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output scs_pkg::res_item_t                   res_item,
	input  logic                                 cfg_valid,
	input  logic [scs_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic                                 cfg_data,
	input  scs_pkg::ctl_cmd_t                    cmd,
	output scs_pkg::ctl_sts_t                    sts
);
	import scs_pkg::*;

	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CW = $clog2(HOLD_DEPTH + 1);
	localparam int KW = $clog2(HOLD_DEPTH + 4);

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// configuration
	logic strip_line_q, strip_doc_q, strip_block_q, keep_blank_q;

	// line state
	logic          in_comment_q, line_blank_q, line_had_comment_q, discard_q;
	logic [1:0]    quote_kind_q, skip_q;
	logic [CW-1:0] hold_count_q;
	logic          hold_ovf_q;

	// plan of the request in flight
	logic [CW-1:0] flush_n_q;
	logic [KW-1:0] total_q;
	logic [KW-1:0] k_q;
	logic [7:0]    tail0_q, tail1_q, tail2_q;
	logic          trunc_q;

	logic [7:0]    hold_mem [HOLD_DEPTH];
	logic [7:0]    rd_data_q;

	logic          res_valid_q;
	res_item_t     res_item_q;

	// decode outputs
	logic          ic_d, lb_d, lhc_d, disc_d, ovf_d;
	logic [1:0]    qk_d, skip_d;
	logic [CW-1:0] count_d;
	logic          flush_d, hold_wr, mk_nb, keep_c, lb_eff;
	logic [1:0]    tn_d;
	logic [7:0]    t0_d, t1_d, t2_d;
	logic          trunc_d;
	logic [1:0]    qk_in;
	logic [KW-1:0] total_d;

	logic [7:0] c, a1, a2;
	assign c  = src_item.src_byte;
	assign a1 = src_item.ahead_one;
	assign a2 = src_item.ahead_two;

	always_comb begin
		ic_d    = in_comment_q;
		lb_d    = line_blank_q;
		lhc_d   = line_had_comment_q;
		disc_d  = discard_q;
		ovf_d   = hold_ovf_q;
		qk_d    = quote_kind_q;
		skip_d  = skip_q;
		count_d = hold_count_q;
		flush_d = 1'b0;
		hold_wr = 1'b0;
		mk_nb   = 1'b0;
		keep_c  = 1'b0;
		tn_d    = 2'd0;
		t0_d    = c;
		t1_d    = a1;
		t2_d    = a2;
		trunc_d = 1'b0;
		qk_in   = (c == CH_DQ) ? QUOTE_DOUBLE : QUOTE_SINGLE;

		priority if (c == CH_NL) begin
			t0_d = CH_NL;
			if (line_blank_q && line_had_comment_q) begin
				tn_d = keep_blank_q ? 2'd1 : 2'd0;
			end else begin
				flush_d = 1'b1;
				tn_d    = 2'd1;
				trunc_d = hold_ovf_q;
			end
			lb_d    = 1'b1;
			lhc_d   = in_comment_q;
			disc_d  = 1'b0;
			skip_d  = 2'd0;
			qk_d    = QUOTE_NONE;
			count_d = '0;
			ovf_d   = 1'b0;
		end else if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
		end else if (discard_q) begin
			// rest of a line comment
		end else if (c == CH_SL) begin
			if (quote_kind_q != QUOTE_NONE) begin
				keep_c = 1'b1;
			end else if (!in_comment_q) begin
				if (strip_line_q && a1 == CH_SL) begin
					disc_d = 1'b1;
					lhc_d  = 1'b1;
				end else if (a1 == CH_ST) begin
					if (strip_doc_q && a2 == CH_ST) begin
						ic_d   = 1'b1;
						lhc_d  = 1'b1;
						skip_d = 2'd1;
					end else if (strip_block_q) begin
						if (a2 == CH_ST) begin
							// doc opener kept verbatim
							mk_nb  = 1'b1;
							tn_d   = 2'd3;
							skip_d = 2'd2;
						end else begin
							ic_d   = 1'b1;
							lhc_d  = 1'b1;
							skip_d = 2'd1;
						end
					end else begin
						keep_c = 1'b1;
					end
				end else begin
					keep_c = 1'b1;
				end
			end
		end else if (c == CH_ST) begin
			if (in_comment_q) begin
				if (a1 == CH_SL) begin
					ic_d   = 1'b0;
					skip_d = 2'd1;
				end
			end else begin
				mk_nb  = 1'b1;
				keep_c = 1'b1;
			end
		end else if (c == CH_DQ || c == CH_SQ) begin
			if (!in_comment_q) begin
				if (quote_kind_q == QUOTE_NONE) begin
					mk_nb = 1'b1;
					qk_d  = qk_in;
				end else if (quote_kind_q == qk_in) begin
					qk_d = QUOTE_NONE;
				end
				keep_c = 1'b1;
			end
		end else if (!in_comment_q) begin
			mk_nb  = !is_space(c);
			keep_c = 1'b1;
		end

		if (mk_nb && line_blank_q) begin
			flush_d = 1'b1;
			lb_d    = 1'b0;
			count_d = '0;
		end
		lb_eff = line_blank_q && !mk_nb;
		if (keep_c) begin
			if (lb_eff) begin
				if (hold_count_q < CW'(HOLD_DEPTH)) begin
					hold_wr = 1'b1;
					count_d = hold_count_q + CW'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end else begin
				tn_d = 2'd1;
			end
		end

		total_d = (flush_d ? KW'(hold_count_q) : '0) + KW'(tn_d);
	end

	// result sequencing
	logic [KW-1:0] k_inc, j, rd_base;
	logic [AW-1:0] rd_addr;
	logic          in_flush;
	res_item_t     next_res;

	assign k_inc    = k_q + KW'(1);
	assign in_flush = k_q < KW'(flush_n_q);
	assign j        = k_q - KW'(flush_n_q);
	assign rd_base  = cmd.emit ? k_inc : k_q;

	always_comb begin
		if (cmd.load || rd_base >= KW'(HOLD_DEPTH)) begin
			rd_addr = '0;
		end else begin
			rd_addr = rd_base[AW-1:0];
		end
	end

	always_comb begin
		next_res.run_last  = (k_inc == total_q);
		next_res.truncated = 1'b0;
		if (in_flush) begin
			next_res.out_byte = rd_data_q;
		end else begin
			next_res.truncated = trunc_q;
			unique case (j[1:0])
				2'd0:    next_res.out_byte = tail0_q;
				2'd1:    next_res.out_byte = tail1_q;
				default: next_res.out_byte = tail2_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && hold_wr) begin
			hold_mem[hold_count_q[AW-1:0]] <= c;
		end
		rd_data_q <= hold_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_line_q       <= 1'b1;
			strip_doc_q        <= 1'b1;
			strip_block_q      <= 1'b1;
			keep_blank_q       <= 1'b0;
			in_comment_q       <= 1'b0;
			quote_kind_q       <= QUOTE_NONE;
			line_blank_q       <= 1'b1;
			line_had_comment_q <= 1'b0;
			discard_q          <= 1'b0;
			skip_q             <= 2'd0;
			hold_count_q       <= '0;
			hold_ovf_q         <= 1'b0;
			k_q                <= '0;
			total_q            <= '0;
			flush_n_q          <= '0;
			res_valid_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_STRIP_LINE:  strip_line_q  <= cfg_data;
					CFG_STRIP_DOC:   strip_doc_q   <= cfg_data;
					CFG_STRIP_BLOCK: strip_block_q <= cfg_data;
					CFG_KEEP_BLANK:  keep_blank_q  <= cfg_data;
					default:         ;
				endcase
			end
			if (cmd.load) begin
				in_comment_q       <= ic_d;
				quote_kind_q       <= qk_d;
				line_blank_q       <= lb_d;
				line_had_comment_q <= lhc_d;
				discard_q          <= disc_d;
				skip_q             <= skip_d;
				hold_count_q       <= count_d;
				hold_ovf_q         <= ovf_d;
				k_q                <= '0;
				total_q            <= total_d;
				flush_n_q          <= flush_d ? hold_count_q : '0;
			end else if (cmd.emit) begin
				k_q <= k_inc;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tail0_q <= t0_d;
			tail1_q <= t1_d;
			tail2_q <= t2_d;
			trunc_q <= trunc_d;
		end
		if (cmd.emit) begin
			res_item_q <= next_res;
		end
	end

	assign res_valid       = res_valid_q;
	assign res_item        = res_item_q;
	assign sts.has_results = (total_d != '0);
	assign sts.last        = (k_inc == total_q);
	assign sts.out_free    = !res_valid_q || !res_stall;

endmodule

>>> rtl/core/source_comment_stripper_core.sv
// ---------------------------------------------------------------------------
// source_comment_stripper_core
// Streaming C comment stripper: one source byte per request, bytes out.
// ---------------------------------------------------------------------------
// Usage:
//   src channel: one request per source byte with two bytes of same-line
//     lookahead (zero past the newline). Accepted when src_valid && !src_stall.
//   res channel: stripped output bytes; run_last marks the last result of a
//     request, truncated flags a newline whose held blank prefix overflowed.
//   cfg channel: register writes (cfg_ready is always high); write only while
//     no request is in flight.
// Flow: a request with no result is only loaded; a request with results
//   then enters the emit state, which sends them in turn while the receiver
//   does not stall. The first non-blank byte of a line also drains the held
//   blank prefix, up to HOLD_DEPTH bytes, one byte a cycle while the receiver
//   does not stall, from the hold store's single read port.
// The first result is loaded into the result register by the emit state that follows acceptance.
// Reset: configuration returns to its reset values, line state clears, no
//   result is pending. The hold store is not cleared.
// Receiver stall: the result register holds; src_stall stays high until the
//   last result of the request is in the result register.
// ---------------------------------------------------------------------------
module source_comment_stripper_core #(
	parameter int HOLD_DEPTH = scs_pkg::HOLD_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	output logic                            src_stall,
	input  scs_pkg::src_item_t              src_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output scs_pkg::res_item_t              res_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [scs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic                            cfg_data
);
	import scs_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	assign cfg_ready = 1'b1;

	scs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	scs_datapath #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> tb/source_comment_stripper_core_tb.sv
// ---------------------------------------------------------------------------
// source_comment_stripper_core_tb
// Self-checking bench for the streaming comment stripper. Source lines are
// sent byte by byte with same-line lookahead; a local model of the stripping
// rules predicts every output byte, and a monitor checks each result in order.
// Directed lines, hold-store overflow, backpressure and random lines are
// covered under several register settings and idle patterns.
// ---------------------------------------------------------------------------
module source_comment_stripper_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scs_pkg::*;

	localparam int HOLD_DEPTH   = HOLD_DEPTH_DEF;
	localparam int LIMIT_CYCLES = 500000;

	logic                   clk;
	logic                   arst_n;
	logic                   src_valid;
	logic                   src_stall;
	src_item_t              src_item;
	logic                   res_valid;
	logic                   res_stall;
	res_item_t              res_item;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic                   cfg_data;

	source_comment_stripper_core #(
		.HOLD_DEPTH(HOLD_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// model of the stripper: register copies and line state
	logic       m_strip_line, m_strip_doc, m_strip_block, m_keep_blank;
	logic       in_cmt, blank_ln, had_cmt, discard_ln, hold_ovf;
	logic [1:0] quote_st;
	logic [1:0] skip_n;
	logic [7:0] hold_mem [HOLD_DEPTH];
	int         hold_n;

	res_item_t  step_out[$];
	res_item_t  stripped_q[$];
	logic [7:0] line_buf[$];

	int src_idle_pct;
	int res_idle_pct;
	int res_hold_n;
	int err_count;
	int cycle_n;

	always #4 clk = ~clk;

	function automatic logic is_ws(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void emit_byte(logic [7:0] b, logic tr);
		res_item_t r;
		r.out_byte  = b;
		r.run_last  = 1'b0;
		r.truncated = tr;
		step_out.push_back(r);
	endfunction

	function automatic void flush_held();
		for (int k = 0; k < hold_n; k++)
			emit_byte(hold_mem[k], 1'b0);
		hold_n = 0;
	endfunction

	function automatic void go_nonblank();
		if (blank_ln) begin
			flush_held();
			blank_ln = 1'b0;
		end
	endfunction

	function automatic void hold_or_emit(logic [7:0] b);
		if (blank_ln) begin
			if (hold_n < HOLD_DEPTH) begin
				hold_mem[hold_n] = b;
				hold_n++;
			end else begin
				hold_ovf = 1'b1;
			end
		end else begin
			emit_byte(b, 1'b0);
		end
	endfunction

	function automatic void reset_model();
		m_strip_line  = 1'b1;
		m_strip_doc   = 1'b1;
		m_strip_block = 1'b1;
		m_keep_blank  = 1'b0;
		in_cmt        = 1'b0;
		quote_st      = QUOTE_NONE;
		blank_ln      = 1'b1;
		had_cmt       = 1'b0;
		discard_ln    = 1'b0;
		skip_n        = 2'd0;
		hold_n        = 0;
		hold_ovf      = 1'b0;
	endfunction

	// works out the output bytes caused by one accepted request
	function automatic void strip_predict(src_item_t it);
		logic [7:0] c, a1, a2;
		logic [1:0] qk;
		res_item_t  r;
		c  = it.src_byte;
		a1 = it.ahead_one;
		a2 = it.ahead_two;
		if (c == CH_NL) begin
			if (blank_ln && had_cmt) begin
				if (m_keep_blank)
					emit_byte(CH_NL, 1'b0);
			end else begin
				flush_held();
				emit_byte(CH_NL, hold_ovf);
			end
			blank_ln   = 1'b1;
			had_cmt    = in_cmt;
			discard_ln = 1'b0;
			skip_n     = 2'd0;
			quote_st   = QUOTE_NONE;
			hold_n     = 0;
			hold_ovf   = 1'b0;
		end else if (skip_n != 2'd0) begin
			skip_n = skip_n - 2'd1;
		end else if (discard_ln) begin
			// tail of a line comment, dropped
		end else if (c == CH_SL) begin
			if (quote_st != QUOTE_NONE) begin
				hold_or_emit(c);
			end else if (!in_cmt) begin
				if (m_strip_line && a1 == CH_SL) begin
					discard_ln = 1'b1;
					had_cmt    = 1'b1;
				end else if (a1 == CH_ST) begin
					if (m_strip_doc && a2 == CH_ST) begin
						in_cmt  = 1'b1;
						had_cmt = 1'b1;
						skip_n  = 2'd1;
					end else if (m_strip_block) begin
						if (a2 == CH_ST) begin
							// doc opener kept whole when block but not doc comments are stripped
							go_nonblank();
							emit_byte(c, 1'b0);
							emit_byte(a1, 1'b0);
							emit_byte(a2, 1'b0);
							skip_n = 2'd2;
						end else begin
							in_cmt  = 1'b1;
							had_cmt = 1'b1;
							skip_n  = 2'd1;
						end
					end else begin
						hold_or_emit(c);
					end
				end else begin
					hold_or_emit(c);
				end
			end
		end else if (c == CH_ST) begin
			if (in_cmt) begin
				if (a1 == CH_SL) begin
					in_cmt = 1'b0;
					skip_n = 2'd1;
				end
			end else begin
				go_nonblank();
				hold_or_emit(c);
			end
		end else if (c == CH_DQ || c == CH_SQ) begin
			if (!in_cmt) begin
				qk = (c == CH_DQ) ? QUOTE_DOUBLE : QUOTE_SINGLE;
				if (quote_st == QUOTE_NONE) begin
					go_nonblank();
					quote_st = qk;
				end else if (quote_st == qk) begin
					quote_st = QUOTE_NONE;
				end
				hold_or_emit(c);
			end
		end else if (!in_cmt) begin
			if (!is_ws(c))
				go_nonblank();
			hold_or_emit(c);
		end
		for (int k = 0; k < step_out.size(); k++) begin
			r = step_out[k];
			r.run_last = (k == step_out.size() - 1);
			stripped_q.push_back(r);
		end
		step_out.delete();
	endfunction

	// receiver: random stall, or a counted hold-off when requested
	always @(negedge clk) begin
		if (res_hold_n > 0) begin
			res_stall <= 1'b1;
			res_hold_n = res_hold_n - 1;
		end else begin
			res_stall <= ($urandom_range(99) < res_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (stripped_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %02h last=%0b trunc=%0b",
					$time, res_item.out_byte, res_item.run_last, res_item.truncated);
				err_count++;
			end else begin
				want = stripped_q.pop_front();
				if (res_item.out_byte !== want.out_byte) begin
					$display("%0t: out_byte mismatch, expected %02h, got %02h",
						$time, want.out_byte, res_item.out_byte);
					err_count++;
				end
				if (res_item.run_last !== want.run_last) begin
					$display("%0t: run_last mismatch, expected %0b, got %0b",
						$time, want.run_last, res_item.run_last);
					err_count++;
				end
				if (res_item.truncated !== want.truncated) begin
					$display("%0t: truncated mismatch, expected %0b, got %0b",
						$time, want.truncated, res_item.truncated);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_n++;
		if (cycle_n > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_item(src_item_t it);
		int gap;
		if ($urandom_range(99) < src_idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			src_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		strip_predict(it);
	endtask

	// sends line_buf byte by byte; lookahead stops at the newline
	task automatic send_line_buf();
		src_item_t it;
		int        n;
		n = line_buf.size();
		for (int i = 0; i < n; i++) begin
			it.src_byte  = line_buf[i];
			it.ahead_one = 8'd0;
			it.ahead_two = 8'd0;
			if (line_buf[i] != CH_NL && i + 1 < n) begin
				it.ahead_one = line_buf[i + 1];
				if (line_buf[i + 1] != CH_NL && i + 2 < n)
					it.ahead_two = line_buf[i + 2];
			end
			// occasional lookahead that disagrees with the stream
			if ($urandom_range(24) == 0) begin
				it.ahead_one = 8'($urandom_range(255));
				it.ahead_two = 8'($urandom_range(255));
			end
			send_item(it);
		end
	endtask

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_ws();
		case ($urandom_range(4))
			0: return 8'd9;
			1: return 8'd11;
			2: return 8'd12;
			3: return 8'd13;
			default: return 8'd32;
		endcase
	endfunction

	task automatic send_line(string s);
		line_buf.delete();
		put_str(s);
		line_buf.push_back(CH_NL);
		send_line_buf();
	endtask

	task automatic src_quiet();
		@(negedge clk);
		src_valid <= 1'b0;
	endtask

	// waits until every predicted byte has come out, plus a short pause for
	// requests that cause no result
	task automatic drain_results();
		src_quiet();
		while (stripped_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_STRIP_LINE:  m_strip_line  = d;
			CFG_STRIP_DOC:   m_strip_doc   = d;
			CFG_STRIP_BLOCK: m_strip_block = d;
			CFG_KEEP_BLANK:  m_keep_blank  = d;
			default: ;
		endcase
	endtask

	// bits: 0 line, 1 doc, 2 block, 3 keep blank
	task automatic set_config(logic [3:0] bits);
		drain_results();
		write_reg(CFG_STRIP_LINE,  bits[0]);
		write_reg(CFG_STRIP_DOC,   bits[1]);
		write_reg(CFG_STRIP_BLOCK, bits[2]);
		write_reg(CFG_KEEP_BLANK,  bits[3]);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic void build_random_line();
		int ntok;
		line_buf.delete();
		if ($urandom_range(9) == 0) begin
			for (int i = 0; i < 30 + $urandom_range(6); i++)
				line_buf.push_back(pick_ws());
		end
		ntok = $urandom_range(8);
		for (int t = 0; t < ntok; t++) begin
			case ($urandom_range(15))
				0, 1:   line_buf.push_back(8'($urandom_range(97, 122)));
				2:      line_buf.push_back(8'($urandom_range(48, 57)));
				3, 4:   for (int i = 0; i <= $urandom_range(3); i++) line_buf.push_back(pick_ws());
				5:      put_str("//");
				6:      put_str("/*");
				7:      put_str("/**");
				8, 9:   put_str("*/");
				10:     line_buf.push_back(CH_DQ);
				11:     line_buf.push_back(CH_SQ);
				12:     line_buf.push_back(CH_SL);
				13:     line_buf.push_back(CH_ST);
				default: begin
					// any byte from 11 up, so never a newline
					line_buf.push_back(8'($urandom_range(11, 255)));
				end
			endcase
		end
		line_buf.push_back(CH_NL);
	endfunction

	task automatic test_directed();
		set_config(4'b1111);
		send_line(" //c");
		send_line("x/**/'//'");
		send_line("/*");
		send_line("*/\"y");
		set_config(4'b0100);
		send_line("/**/");
		send_item({8'hff, 8'h00, 8'h00});
		send_item({8'h00, 8'hff, 8'hff});
		send_item({CH_NL, 8'h00, 8'h00});
	endtask

	task automatic test_config_extremes();
		set_config(4'b0000);
		send_line("/*a*/b");
		set_config(4'b1111);
		send_line("/*a*/b");
	endtask

	task automatic test_hold_overflow();
		set_config(4'b0111);
		line_buf.delete();
		for (int i = 0; i < HOLD_DEPTH + 1; i++) line_buf.push_back(pick_ws());
		put_str("z");
		line_buf.push_back(CH_NL);
		send_line_buf();
		// overflowing prefix on a dropped line reports nothing
		line_buf.delete();
		for (int i = 0; i < HOLD_DEPTH + 1; i++) line_buf.push_back(pick_ws());
		put_str("//");
		line_buf.push_back(CH_NL);
		send_line_buf();
	endtask

	task automatic test_backpressure();
		set_config(4'b0111);
		src_idle_pct = 0;
		@(posedge clk);
		res_hold_n = 300;
		send_line(" a/*b*/c");
		// sender stops here until the block has drained
		drain_results();
	endtask

	task automatic run_random(int n_items, int sidle, int ridle);
		int sent;
		int lines;
		src_idle_pct = sidle;
		res_idle_pct = ridle;
		sent  = 0;
		lines = 0;
		while (sent < n_items) begin
			if (lines % 2 == 0)
				set_config(4'($urandom_range(15)));
			build_random_line();
			sent += line_buf.size();
			send_line_buf();
			lines++;
		end
	endtask

	task automatic test_random();
		run_random(1, 12, 54);
		run_random(1, 54, 12);
		run_random(1, 0, 0);
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		src_valid    = 1'b0;
		src_item     = '0;
		res_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_STRIP_LINE;
		cfg_data     = 1'b0;
		src_idle_pct = 12;
		res_idle_pct = 54;
		res_hold_n   = 0;
		err_count    = 0;
		cycle_n      = 0;
		reset_model();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_config_extremes();
		test_hold_overflow();
		test_backpressure();
		test_random();

		drain_results();
		repeat (16) @(posedge clk);
		if (err_count == 0 && stripped_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/scs_pkg.sv
rtl/core/scs_ctrl.sv
rtl/core/scs_datapath.sv
rtl/core/source_comment_stripper_core.sv
tb/source_comment_stripper_core_tb.sv
